### sv/pce_pkg.sv
// shared constants and bit-step functions for the parameterized crc engine
package pce_pkg;

  localparam int CRC_MAX_W = 64;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int WIDTH_W   = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CRC_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR_POLY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VALUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_IS_AUG    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REFLECT_INPUT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REFLECT_OUTPUT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_XOR      = 3'd6;

  // reset values of the configuration registers
  localparam logic [WIDTH_W-1:0]   RST_CRC_WIDTH      = 7'd32;
  localparam logic [CRC_MAX_W-1:0] RST_GENERATOR_POLY = 64'h0000_0000_04C1_1DB7;
  localparam logic [CRC_MAX_W-1:0] RST_INITIAL_VALUE  = 64'h0000_0000_FFFF_FFFF;
  localparam logic                 RST_INIT_IS_AUG    = 1'b0;
  localparam logic                 RST_REFLECT_INPUT  = 1'b1;
  localparam logic                 RST_REFLECT_OUTPUT = 1'b1;
  localparam logic [CRC_MAX_W-1:0] RST_FINAL_XOR      = 64'h0000_0000_FFFF_FFFF;

  // one forward step: shift in b, fold in the polynomial if the top bit fell out
  function automatic logic [CRC_MAX_W-1:0] fwd_step(input logic [CRC_MAX_W-1:0] r,
                                                     input logic b,
                                                     input logic [CRC_MAX_W-1:0] mask,
                                                     input logic [CRC_MAX_W-1:0] top,
                                                     input logic [CRC_MAX_W-1:0] poly);
    logic                 out_bit;
    logic [CRC_MAX_W-1:0] n;
    out_bit = |(r & top);
    n = ((r << 1) | {{(CRC_MAX_W-1){1'b0}}, b}) & mask;
    if (out_bit) begin
      n = n ^ poly;
    end
    return n;
  endfunction

  // one reverse step: undo a forward step that shifted in a zero
  function automatic logic [CRC_MAX_W-1:0] rev_step(input logic [CRC_MAX_W-1:0] r,
                                                     input logic [CRC_MAX_W-1:0] top,
                                                     input logic [CRC_MAX_W-1:0] poly);
    logic                 low;
    logic [CRC_MAX_W-1:0] n;
    low = r[0];
    n = low ? (r ^ poly) : r;
    n = n >> 1;
    if (low) begin
      n = n | top;
    end
    return n;
  endfunction

  // shift one byte in, msb first
  function automatic logic [CRC_MAX_W-1:0] byte_steps(input logic [CRC_MAX_W-1:0] r,
                                                       input logic [BYTE_W-1:0] d,
                                                       input logic [CRC_MAX_W-1:0] mask,
                                                       input logic [CRC_MAX_W-1:0] top,
                                                       input logic [CRC_MAX_W-1:0] poly);
    logic [CRC_MAX_W-1:0] n;
    n = r;
    for (int i = 0; i < BYTE_W; i++) begin
      n = fwd_step(n, d[BYTE_W-1-i], mask, top, poly);
    end
    return n;
  endfunction

  // zero-bit steps grp*8 .. grp*8+7, each only while below the width
  function automatic logic [CRC_MAX_W-1:0] zero_steps(input logic [CRC_MAX_W-1:0] r,
                                                       input logic [2:0] grp,
                                                       input logic [WIDTH_W-1:0] w,
                                                       input logic [CRC_MAX_W-1:0] mask,
                                                       input logic [CRC_MAX_W-1:0] top,
                                                       input logic [CRC_MAX_W-1:0] poly);
    logic [CRC_MAX_W-1:0] n;
    n = r;
    for (int i = 0; i < BYTE_W; i++) begin
      if ({1'b0, grp, 3'(i)} < w) begin
        n = fwd_step(n, 1'b0, mask, top, poly);
      end
    end
    return n;
  endfunction

  // reverse steps grp*8 .. grp*8+7, each only while below the width
  function automatic logic [CRC_MAX_W-1:0] rev_steps(input logic [CRC_MAX_W-1:0] r,
                                                      input logic [2:0] grp,
                                                      input logic [WIDTH_W-1:0] w,
                                                      input logic [CRC_MAX_W-1:0] top,
                                                      input logic [CRC_MAX_W-1:0] poly);
    logic [CRC_MAX_W-1:0] n;
    n = r;
    for (int i = 0; i < BYTE_W; i++) begin
      if ({1'b0, grp, 3'(i)} < w) begin
        n = rev_step(n, top, poly);
      end
    end
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] reverse8(input logic [BYTE_W-1:0] d);
    logic [BYTE_W-1:0] n;
    for (int i = 0; i < BYTE_W; i++) begin
      n[i] = d[BYTE_W-1-i];
    end
    return n;
  endfunction

  function automatic logic [CRC_MAX_W-1:0] reverse64(input logic [CRC_MAX_W-1:0] d);
    logic [CRC_MAX_W-1:0] n;
    for (int i = 0; i < CRC_MAX_W; i++) begin
      n[i] = d[CRC_MAX_W-1-i];
    end
    return n;
  endfunction

endpackage

### sv/parameterized_crc_engine.sv
// parameterized crc engine: byte stream in, finished crc out
//
// Usage: message bytes arrive on the s_ stream, one byte per beat, with
// s_tuser marking the first byte (register reload) and s_tlast the last.
// One finished crc leaves on the m_ stream for every last byte. The cfg
// channel writes the crc registers by index and is always ready.
// Throughput: one byte per cycle while s_tready is high. The crc of a message
// appears on m_tdata once its last byte has passed the registers in order: the
// byte steps run in the accepting cycle, then eight stages of up to eight appended
// zero bits each (only while below the width) and one output stage.
// After reset, and after a write to the width, polynomial or initial value,
// the preset is converted to augmented form by an 8-step-per-cycle unit;
// s_tready is low while it runs through its load and run states.
// A byte without the first mark that follows a last byte waits until that
// message's appended zeros are done (longer while m_tready stalls the zero
// pipeline), since it continues from that register value. When m_tvalid is
// high and m_tready low the zero pipeline holds; non-last bytes are still taken,
// last bytes wait for a free slot.
module parameterized_crc_engine (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  logic                           s_tuser,   // [0] first_byte
  input  logic                           s_tlast,   // last_byte
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [pce_pkg::CRC_MAX_W-1:0]  m_tdata,   // [63:0] crc_value
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pce_pkg::CRC_MAX_W-1:0]  cfg_data
);

  localparam int W      = pce_pkg::CRC_MAX_W;
  localparam int NSTAGE = W / pce_pkg::BYTE_W;

  // preset conversion states
  localparam logic [1:0] CV_IDLE = 2'd0;
  localparam logic [1:0] CV_LOAD = 2'd1;
  localparam logic [1:0] CV_RUN  = 2'd2;

  // configuration registers
  logic [pce_pkg::WIDTH_W-1:0] crc_width;
  logic [W-1:0]                generator_poly;
  logic [W-1:0]                initial_value;
  logic                        init_is_augmented;
  logic                        reflect_input;
  logic                        reflect_output;
  logic [W-1:0]                final_xor;

  // preset conversion unit
  logic [1:0]   conv_state;
  logic [2:0]   conv_cnt;
  logic [W-1:0] conv_reg;
  logic         conv_restart;

  // crc register and zero-append pipeline
  logic [W-1:0]   crc_reg;
  logic [NSTAGE:0] p_val;
  logic [NSTAGE:0] p_lat;
  logic [NSTAGE:0] p_lat_next;
  logic [W-1:0]   p_data [0:NSTAGE];
  logic [W-1:0]   z_out  [0:NSTAGE-1];

  logic [pce_pkg::WIDTH_W-1:0] w_eff;
  logic [W-1:0]                mask;
  logic [W-1:0]                top;
  logic [W-1:0]                poly_m;
  logic [W-1:0]                aug_init;
  logic [pce_pkg::BYTE_W-1:0]  byte_in;
  logic [W-1:0]                start_r;
  logic [W-1:0]                byte_r;
  logic [W-1:0]                refl;
  logic [W-1:0]                fmt;
  logic                        init_busy;
  logic                        pending;
  logic                        pipe_adv;
  logic                        in_acc;
  logic                        wback;

  // effective width, mask and top bit
  always_comb begin
    if (crc_width == '0) begin
      w_eff = 7'd1;
    end else if (crc_width > 7'(W)) begin
      w_eff = 7'(W);
    end else begin
      w_eff = crc_width;
    end
    for (int i = 0; i < W; i++) begin
      mask[i] = (7'(i) < w_eff);
    end
    top    = mask & ~(mask >> 1);
    poly_m = generator_poly & mask;
  end

  assign init_busy = (conv_state != CV_IDLE);
  assign cfg_ready = 1'b1;
  assign aug_init  = init_is_augmented ? (initial_value & mask) : conv_reg;

  // preset depends on width, polynomial and initial value
  assign conv_restart = cfg_valid && cfg_ready &&
                        (cfg_index inside {pce_pkg::REG_CRC_WIDTH, pce_pkg::REG_GENERATOR_POLY,
                                           pce_pkg::REG_INITIAL_VALUE});

  // handshake control
  assign pending  = |(p_val & p_lat);
  assign pipe_adv = !m_tvalid || m_tready;
  assign s_tready = !init_busy && (s_tuser || !pending) && (!s_tlast || pipe_adv);
  assign in_acc   = s_tvalid && s_tready;
  assign wback    = p_val[NSTAGE] && p_lat[NSTAGE];

  // byte step and zero-append stages
  always_comb begin
    byte_in = reflect_input ? pce_pkg::reverse8(s_tdata) : s_tdata;
    start_r = s_tuser ? aug_init : (crc_reg & mask);
    byte_r  = pce_pkg::byte_steps(start_r, byte_in, mask, top, poly_m);
    for (int k = 0; k < NSTAGE; k++) begin
      z_out[k] = pce_pkg::zero_steps(p_data[k], 3'(k), w_eff, mask, top, poly_m);
    end
  end

  // output reflection, final xor and mask
  always_comb begin
    refl = pce_pkg::reverse64(p_data[NSTAGE]) >> (7'(W) - w_eff);
    fmt  = ((reflect_output ? refl : p_data[NSTAGE]) ^ final_xor) & mask;
  end

  // latest-writer flags: only the newest message may write back its register
  always_comb begin
    p_lat_next = p_lat;
    if (wback) begin
      p_lat_next[NSTAGE] = 1'b0;
    end
    if (pipe_adv) begin
      p_lat_next = {p_lat_next[NSTAGE-1:0], in_acc && s_tlast};
    end
    if (in_acc) begin
      p_lat_next = {{NSTAGE{1'b0}}, pipe_adv && s_tlast};
    end
  end

  // configuration registers and preset conversion
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_width         <= pce_pkg::RST_CRC_WIDTH;
      generator_poly    <= pce_pkg::RST_GENERATOR_POLY;
      initial_value     <= pce_pkg::RST_INITIAL_VALUE;
      init_is_augmented <= pce_pkg::RST_INIT_IS_AUG;
      reflect_input     <= pce_pkg::RST_REFLECT_INPUT;
      reflect_output    <= pce_pkg::RST_REFLECT_OUTPUT;
      final_xor         <= pce_pkg::RST_FINAL_XOR;
      conv_state        <= CV_LOAD;
      conv_cnt          <= '0;
    end else begin
      if (conv_restart) begin
        conv_state <= CV_LOAD;
      end else begin
        case (conv_state)
          CV_LOAD: begin
            conv_reg   <= initial_value & mask;
            conv_cnt   <= '0;
            conv_state <= CV_RUN;
          end
          CV_RUN: begin
            conv_reg <= pce_pkg::rev_steps(conv_reg, conv_cnt, w_eff, top, poly_m);
            conv_cnt <= conv_cnt + 3'd1;
            if (conv_cnt == 3'd7) begin
              conv_state <= CV_IDLE;
            end
          end
          default: begin
            conv_state <= CV_IDLE;
          end
        endcase
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pce_pkg::REG_CRC_WIDTH:      crc_width         <= cfg_data[pce_pkg::WIDTH_W-1:0];
          pce_pkg::REG_GENERATOR_POLY: generator_poly    <= cfg_data;
          pce_pkg::REG_INITIAL_VALUE:  initial_value     <= cfg_data;
          pce_pkg::REG_INIT_IS_AUG:    init_is_augmented <= cfg_data[0];
          pce_pkg::REG_REFLECT_INPUT:  reflect_input     <= cfg_data[0];
          pce_pkg::REG_REFLECT_OUTPUT: reflect_output    <= cfg_data[0];
          pce_pkg::REG_FINAL_XOR:      final_xor         <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // control of crc register, pipeline and output
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg  <= '0;
      p_val    <= '0;
      p_lat    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      p_lat <= p_lat_next;
      if (pipe_adv) begin
        p_val    <= {p_val[NSTAGE-1:0], in_acc && s_tlast};
        m_tvalid <= p_val[NSTAGE];
      end
      if (in_acc && !s_tlast) begin
        crc_reg <= byte_r;
      end else if (wback) begin
        crc_reg <= p_data[NSTAGE];
      end
    end
  end

  // pipeline and output payload
  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      p_data[0] <= byte_r;
      for (int k = 0; k < NSTAGE; k++) begin
        p_data[k+1] <= z_out[k];
      end
      m_tdata <= fmt;
    end
  end

endmodule
